>>> sv/tsnb_pkg.sv
package tsnb_pkg;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CHAN   = 2'd2;
  localparam logic [1:0] REG_FILTER = 2'd3;

  localparam logic [2:0] CC_GRAY  = 3'd1;
  localparam logic [2:0] CC_GRAYA = 3'd2;
  localparam logic [2:0] CC_RGB   = 3'd3;
  localparam logic [2:0] CC_RGBA  = 3'd4;

  localparam logic FILT_NEAREST = 1'b0;

  localparam int ADDR_W = 16;
  localparam int CH_W   = 10;   // channel in units of 1/512
  localparam int OUT_W  = 17;

  typedef logic [CH_W-1:0] chan_t;

  typedef struct packed {
    logic              ok;
    logic [3:0][CH_W-1:0] ch;
  } texel_t;

  typedef struct packed {
    logic valid;
    logic sample;
  } ctl_t;

  function automatic chan_t byte_val(input logic [7:0] b);
    byte_val = {1'b0, b, 1'b1};
  endfunction

  function automatic texel_t expand(input logic [31:0] raw, input logic [2:0] cc);
    texel_t t;
    t.ok = 1'b1;
    t.ch = '0;
    case (cc)
      CC_GRAY: begin
        t.ch[0] = byte_val(raw[7:0]); t.ch[1] = t.ch[0]; t.ch[2] = t.ch[0];
        t.ch[3] = chan_t'(512);
      end
      CC_GRAYA: begin
        t.ch[0] = byte_val(raw[7:0]); t.ch[1] = t.ch[0]; t.ch[2] = t.ch[0];
        t.ch[3] = byte_val(raw[15:8]);
      end
      CC_RGB: begin
        t.ch[0] = byte_val(raw[7:0]); t.ch[1] = byte_val(raw[15:8]);
        t.ch[2] = byte_val(raw[23:16]); t.ch[3] = chan_t'(512);
      end
      CC_RGBA: begin
        t.ch[0] = byte_val(raw[7:0]); t.ch[1] = byte_val(raw[15:8]);
        t.ch[2] = byte_val(raw[23:16]); t.ch[3] = byte_val(raw[31:24]);
      end
      default: t.ok = 1'b0;
    endcase
    expand = t;
  endfunction

endpackage

>>> sv/tsnb_coord.sv
module tsnb_coord #(
  parameter int F  = 16,
  parameter int WB = 9,
  parameter int HB = 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  tsnb_pkg::ctl_t            ctl_in,
  input  logic [15:0]               texel_index,
  input  logic [31:0]               raw_in,
  input  logic [15:0]               u_frac,
  input  logic [15:0]               v_frac,
  input  logic [WB-1:0]             w,
  input  logic [HB-1:0]             h,
  output tsnb_pkg::ctl_t            ctl_out,
  output logic [3:0][15:0]          addr,
  output logic [31:0]               raw_out,
  output logic [F-1:0]              c1_out,
  output logic [F-1:0]              c2_out
);
  import tsnb_pkg::*;

  ctl_t ctl1, ctl2, ctl3;
  logic [15:0] idx1, idx2, idx3;
  logic [31:0] raw1, raw2, raw3;
  logic [F+WB-1:0] up1;
  logic [F+HB-1:0] vp1;
  logic [WB-1:0] a2, a1_2, a3, a1_3;
  logic [HB-1:0] b2, b1_2;
  logic [F-1:0] c1_2, c2_2, c1_3, c2_3;
  logic [15:0] rb3, rb1_3;

  logic [WB-1:0] a_n, a1_n;
  logic [HB-1:0] b_n, b1_n, vi;

  always_comb begin
    a_n  = up1[F+WB-1:F];
    vi   = vp1[F+HB-1:F];
    b_n  = h - HB'(1) - vi;
    a1_n = ((WB+1)'(a_n) + (WB+1)'(1) >= (WB+1)'(w)) ? '0 : a_n + WB'(1);
    b1_n = (b_n == '0) ? h - HB'(1) : b_n - HB'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0; ctl2 <= '0; ctl3 <= '0; ctl_out <= '0;
    end else if (en) begin
      ctl1 <= ctl_in; ctl2 <= ctl1; ctl3 <= ctl2; ctl_out <= ctl3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1 <= texel_index;
      raw1 <= raw_in;
      up1  <= (F+WB)'(F'(u_frac)) * (F+WB)'(w);
      vp1  <= (F+HB)'(F'(v_frac)) * (F+HB)'(h);
      idx2 <= idx1; raw2 <= raw1;
      a2 <= a_n; a1_2 <= a1_n; b2 <= b_n; b1_2 <= b1_n;
      c1_2 <= up1[F-1:0]; c2_2 <= vp1[F-1:0];
      idx3 <= idx2; raw3 <= raw2;
      a3 <= a2; a1_3 <= a1_2; c1_3 <= c1_2; c2_3 <= c2_2;
      rb3   <= 16'((HB+WB)'(b2) * (HB+WB)'(w));
      rb1_3 <= 16'((HB+WB)'(b1_2) * (HB+WB)'(w));
      addr[0] <= ctl3.sample ? rb3 + 16'(a3) : idx3;
      addr[1] <= rb3 + 16'(a1_3);
      addr[2] <= rb1_3 + 16'(a3);
      addr[3] <= rb1_3 + 16'(a1_3);
      raw_out <= raw3;
      c1_out <= c1_3;
      c2_out <= c2_3;
    end
  end

endmodule

>>> sv/tsnb_mem.sv
module tsnb_mem (
  input  logic        clk,
  input  logic        en,
  input  logic        we,
  input  logic [15:0] waddr,
  input  logic [31:0] wdata,
  input  logic [15:0] raddr,
  output logic [31:0] rdata
);
  logic [31:0] mem [0:65535];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (en) rdata <= mem[raddr];
  end

endmodule

>>> sv/tsnb_filter.sv
module tsnb_filter #(
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  tsnb_pkg::ctl_t        ctl_in,
  input  logic                  no_tex_in,
  input  logic [3:0][31:0]      q,
  input  logic [2:0]            chan_count,
  input  logic                  filt,
  input  logic [F-1:0]          c1,
  input  logic [F-1:0]          c2,
  output logic                  out_valid,
  output logic [3:0][16:0]      rgba,
  output logic                  no_tex_out
);
  import tsnb_pkg::*;

  localparam int TW = F + 10;
  localparam int SW = 2 * F + 10;
  localparam int SH = 2 * F - 7;

  ctl_t ctl6, ctl7;
  logic zero6, zero7, nt6, nt7, near6, near7;
  logic [3:0][TW-1:0] top6, bot6;
  logic [3:0][SW-1:0] sum7;
  logic [3:0][16:0] nr6, nr7;
  logic [F-1:0] c2_6;

  texel_t t00, t01, t10, t11;
  logic [F:0] wa, wb, wc, wd;
  logic [3:0][TW-1:0] top_n, bot_n;
  logic [3:0][SW-1:0] sum_n;
  logic [3:0][16:0] res_n;

  always_comb begin
    t00 = expand(q[0], chan_count);
    t01 = expand(q[1], chan_count);
    t10 = expand(q[2], chan_count);
    t11 = expand(q[3], chan_count);
    wa = {1'b1, {F{1'b0}}} - {1'b0, c1};
    wb = {1'b0, c1};
    wc = {1'b1, {F{1'b0}}} - {1'b0, c2_6};
    wd = {1'b0, c2_6};
    for (int k = 0; k < 4; k++) begin
      top_n[k] = TW'(t00.ch[k]) * TW'(wa) + TW'(t01.ch[k]) * TW'(wb);
      bot_n[k] = TW'(t10.ch[k]) * TW'(wa) + TW'(t11.ch[k]) * TW'(wb);
      sum_n[k] = SW'(top6[k]) * SW'(wc) + SW'(bot6[k]) * SW'(wd);
      res_n[k] = zero7 ? '0 :
                 near7 ? nr7[k] :
                 17'((sum7[k] + (SW'(1) << (SH - 1))) >> SH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl6 <= '0; ctl7 <= '0; out_valid <= 1'b0;
    end else if (en) begin
      ctl6 <= ctl_in; ctl7 <= ctl6;
      out_valid <= ctl7.valid && ctl7.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero6 <= no_tex_in || !t00.ok;
      nt6   <= no_tex_in;
      near6 <= (filt == FILT_NEAREST);
      c2_6  <= c2;
      top6  <= top_n;
      bot6  <= bot_n;
      for (int k = 0; k < 4; k++) nr6[k] <= {t00.ch[k], 7'd0};
      zero7 <= zero6; nt7 <= nt6; near7 <= near6; nr7 <= nr6;
      sum7  <= sum_n;
      rgba  <= res_n;
      no_tex_out <= nt7;
    end
  end

endmodule

>>> sv/texture_sampler_nearest_bilinear.sv
// Channel  Direction  Handshake             Payload
// s_*      in         s_tvalid / s_tready   load texel or sample (u, v)
// m_*      out        m_tvalid / m_tready   RGBA Q1.16 plus no_texture flag
// cfg_*    in         cfg_valid / cfg_ready register index + data
//
// Eight register stages from s_* to m_*; one transaction per cycle while not stalled.
// Loads run the same pipe and write the four store banks at the memory stage,
// so a later sample always reads them; loads give no output transaction.
// Store is four 64K x 32 banks (one read port each) for the four bilinear taps.
// rst is synchronous and clears control only; the store is undefined until written.
// m_tready low with a result waiting freezes the whole pipe; nothing is lost.
module texture_sampler_nearest_bilinear #(
  parameter int MAX_WIDTH       = 256,
  parameter int MAX_HEIGHT      = 256,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] texel_index, [23:16] byte0, [31:24] byte1, [39:32] byte2,
  // [47:40] byte3, [63:48] u_frac, [79:64] v_frac
  input  logic [79:0] s_tdata,
  // [0] action
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [16:0] red, [33:17] green, [50:34] blue, [67:51] alpha, [71:68] zero
  output logic [71:0] m_tdata,
  // [0] no_texture
  output logic [0:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import tsnb_pkg::*;

  localparam int F  = COORD_FRAC_BITS;
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);

  logic       en;
  logic [8:0] width_used, height_used;
  logic [2:0] channel_count;
  logic       filter_mode;
  logic       present;

  logic [WB-1:0] w;
  logic [HB-1:0] h;

  ctl_t ctl_in, ctl4, ctl5;
  logic [3:0][15:0] addr4;
  logic [31:0] raw4;
  logic [F-1:0] c1_4, c2_4, c1_5, c2_5;
  logic [3:0][31:0] q;
  logic no_tex5;
  logic [3:0][16:0] rgba;
  logic load4;

  // Whole pipe advances unless a result sits unaccepted at the output.
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_used    <= 9'd256;
      height_used   <= 9'd256;
      channel_count <= CC_RGBA;
      filter_mode   <= FILT_NEAREST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  width_used    <= cfg_data;
        REG_HEIGHT: height_used   <= cfg_data;
        REG_CHAN:   channel_count <= cfg_data[2:0];
        REG_FILTER: filter_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Size 0 behaves as 1; oversize saturates at the maximum.
  always_comb begin
    w = (width_used == '0) ? WB'(1) :
        ((32'(width_used) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(width_used));
    h = (height_used == '0) ? HB'(1) :
        ((32'(height_used) > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(height_used));
  end

  assign ctl_in.valid  = s_tvalid;
  assign ctl_in.sample = (s_tuser[0] == ACT_SAMPLE);

  tsnb_coord #(.F(F), .WB(WB), .HB(HB)) u_coord (
    .clk(clk), .rst(rst), .en(en), .ctl_in(ctl_in),
    .texel_index(s_tdata[15:0]), .raw_in(s_tdata[47:16]),
    .u_frac(s_tdata[63:48]), .v_frac(s_tdata[79:64]),
    .w(w), .h(h), .ctl_out(ctl4), .addr(addr4), .raw_out(raw4),
    .c1_out(c1_4), .c2_out(c2_4)
  );

  assign load4 = en && ctl4.valid && !ctl4.sample;

  for (genvar k = 0; k < 4; k++) begin : g_bank
    tsnb_mem u_mem (
      .clk(clk), .en(en), .we(load4), .waddr(addr4[0]), .wdata(raw4),
      .raddr(addr4[k]), .rdata(q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
      ctl5    <= '0;
    end else if (en) begin
      ctl5 <= ctl4;
      if (ctl4.valid && !ctl4.sample) present <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      no_tex5 <= !present;
      c1_5    <= c1_4;
      c2_5    <= c2_4;
    end
  end

  tsnb_filter #(.F(F)) u_filter (
    .clk(clk), .rst(rst), .en(en), .ctl_in(ctl5), .no_tex_in(no_tex5),
    .q(q), .chan_count(channel_count), .filt(filter_mode),
    .c1(c1_5), .c2(c2_5), .out_valid(m_tvalid), .rgba(rgba),
    .no_tex_out(m_tuser[0])
  );

  assign m_tdata = {4'd0, rgba[3], rgba[2], rgba[1], rgba[0]};

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready)) else $error("ready/stall mismatch");
  a_notex_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[67:0] == '0) else $error("colors without texture");
  a_present: assert property (@(posedge clk) disable iff (rst)
    present |=> present) else $error("texture flag dropped");
  a_alpha_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[67:51] <= 17'd65536) else $error("alpha above one");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

// Texture sampler testbench.
// A queue of pending transactions, filled by the stimulus process, feeds the
// slave-side driver. Accepted loads update a scoreboard model of the texel
// store and filter, which predicts the RGBA result of each accepted sample; the
// master-side monitor compares every result transaction field by field against
// the oldest prediction. Configuration changes only when the pipe has drained.
module tb;
  import tsnb_pkg::*;

  typedef struct packed {
    logic [0:0]  act;
    logic [79:0] data;
  } xact_t;

  typedef struct packed {
    logic [16:0] red;
    logic [16:0] green;
    logic [16:0] blue;
    logic [16:0] alpha;
    logic        no_tex;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  texture_sampler_nearest_bilinear i_dut (.*);

  always #2 clk = ~clk;

  // shadow of the block's registers and texel store
  logic [8:0]  width_reg = 9'd256;
  logic [8:0]  height_reg = 9'd256;
  logic [2:0]  chan_reg = CC_RGBA;
  logic        filt_reg = FILT_NEAREST;
  logic [31:0] texel_mem [0:65535];
  logic        tex_loaded = 1'b0;
  bit          queued_load [0:65535];   // address already covered by a queued load

  xact_t  pending_q[$];
  pixel_t pixel_q[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int n_loads = 0;
  int n_samples = 0;
  int n_results = 0;
  int cycles = 0;
  bit sent_taken = 1'b0;   // current s_tdata was accepted at the last rising edge

  function automatic longint unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > 256) return 256;
    return width_reg;
  endfunction

  function automatic longint unsigned eff_h();
    if (height_reg == 0) return 1;
    if (height_reg > 256) return 256;
    return height_reg;
  endfunction

  // store address of bilinear tap k (bit0: next column, bit1: next row up in v)
  function automatic logic [15:0] tap_addr(input logic [15:0] u, input logic [15:0] v,
                                           input int k);
    longint unsigned w, h, a, b, a1, b1, row, col;
    w = eff_w();
    h = eff_h();
    a = (longint'(u) * w) >> 16;
    b = h - 1 - ((longint'(v) * h) >> 16);
    a1 = (a + 1 >= w) ? 0 : a + 1;
    b1 = (b == 0) ? h - 1 : b - 1;
    row = k[1] ? b1 : b;
    col = k[0] ? a1 : a;
    return 16'((row * w + col) & 64'hFFFF);
  endfunction

  // one texel expanded to RGBA in units of 1/512
  function automatic void unpack_texel(input logic [31:0] raw, output longint unsigned c[4],
                                       output bit ok);
    longint unsigned bv[4];
    for (int i = 0; i < 4; i++) bv[i] = 2 * longint'(raw[8*i +: 8]) + 1;
    ok = 1'b1;
    case (chan_reg)
      CC_GRAY:  begin c[0] = bv[0]; c[1] = bv[0]; c[2] = bv[0]; c[3] = 512; end
      CC_GRAYA: begin c[0] = bv[0]; c[1] = bv[0]; c[2] = bv[0]; c[3] = bv[1]; end
      CC_RGB:   begin c[0] = bv[0]; c[1] = bv[1]; c[2] = bv[2]; c[3] = 512; end
      CC_RGBA:  begin c[0] = bv[0]; c[1] = bv[1]; c[2] = bv[2]; c[3] = bv[3]; end
      default:  begin c = '{0, 0, 0, 0}; ok = 1'b0; end
    endcase
  endfunction

  function automatic pixel_t filter_texels(input logic [15:0] u, input logic [15:0] v);
    pixel_t px;
    longint unsigned p[4][4];
    longint unsigned res[4];
    longint unsigned c1, c2, top, bot, sum;
    bit ok, dummy;
    res = '{0, 0, 0, 0};
    px.no_tex = ~tex_loaded;
    if (tex_loaded) begin
      c1 = (longint'(u) * eff_w()) & 64'hFFFF;
      c2 = (longint'(v) * eff_h()) & 64'hFFFF;
      unpack_texel(texel_mem[tap_addr(u, v, 0)], p[0], ok);
      if (ok && filt_reg == FILT_NEAREST) begin
        for (int k = 0; k < 4; k++) res[k] = p[0][k] * 128;
      end else if (ok) begin
        for (int t = 1; t < 4; t++) unpack_texel(texel_mem[tap_addr(u, v, t)], p[t], dummy);
        for (int k = 0; k < 4; k++) begin
          top = p[0][k] * (65536 - c1) + p[1][k] * c1;
          bot = p[2][k] * (65536 - c1) + p[3][k] * c1;
          sum = top * (65536 - c2) + bot * c2;
          res[k] = (sum + (64'd1 << 24)) >> 25;
        end
      end
    end
    px.red = res[0][16:0];
    px.green = res[1][16:0];
    px.blue = res[2][16:0];
    px.alpha = res[3][16:0];
    return px;
  endfunction

  // ---------------- stimulus helpers ----------------
  task automatic queue_load(input logic [15:0] idx);
    xact_t x;
    x.act = ACT_LOAD;
    x.data = {32'($urandom), $urandom(), idx};
    queued_load[idx] = 1'b1;
    pending_q.push_back(x);
  endtask

  // once anything is loaded or queued, load each tap not yet written, then the sample
  task automatic queue_sample(input logic [15:0] u, input logic [15:0] v);
    xact_t x;
    logic [15:0] ad;
    if (tex_loaded || pending_q.size() != 0 || n_loads != 0) begin
      for (int k = 0; k < 4; k++) begin
        ad = tap_addr(u, v, k);
        if (!queued_load[ad]) queue_load(ad);
      end
    end
    x.act = ACT_SAMPLE;
    x.data = {v, u, 48'($urandom) ^ {$urandom(), 16'h0}};
    pending_q.push_back(x);
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || s_tvalid || pixel_q.size() != 0) @(posedge clk);
    // loads still in the 8-stage pipe produce no result
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:  width_reg = val;
      REG_HEIGHT: height_reg = val;
      REG_CHAN:   chan_reg = val[2:0];
      default:    filt_reg = val[0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------- slave-side driver ----------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
      if (!s_tvalid || sent_taken) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          xact_t x;
          x = pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= x.data;
          s_tuser <= x.act;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitors and scoreboard ----------------
  always @(posedge clk) begin
    pixel_t got, want;
    cycles++;
    if (cycles > 400000) begin
      $display("%0t timeout: %0d results outstanding", $time, pixel_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      sent_taken = s_tvalid && s_tready;
      if (sent_taken) begin
        if (s_tuser == ACT_LOAD) begin
          texel_mem[s_tdata[15:0]] = s_tdata[47:16];
          tex_loaded = 1'b1;
          n_loads++;
        end else begin
          pixel_q.push_back(filter_texels(s_tdata[63:48], s_tdata[79:64]));
          n_samples++;
        end
      end
      if (m_tvalid && m_tready) begin
        n_results++;
        got.red = m_tdata[16:0];
        got.green = m_tdata[33:17];
        got.blue = m_tdata[50:34];
        got.alpha = m_tdata[67:51];
        got.no_tex = m_tuser[0];
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result transaction: %h nt=%b", $time, got, got.no_tex);
        end else begin
          want = pixel_q.pop_front();
          if (got.red !== want.red) begin
            errors++;
            $display("%0t red: expected %h actual %h", $time, want.red, got.red);
          end
          if (got.green !== want.green) begin
            errors++;
            $display("%0t green: expected %h actual %h", $time, want.green, got.green);
          end
          if (got.blue !== want.blue) begin
            errors++;
            $display("%0t blue: expected %h actual %h", $time, want.blue, got.blue);
          end
          if (got.alpha !== want.alpha) begin
            errors++;
            $display("%0t alpha: expected %h actual %h", $time, want.alpha, got.alpha);
          end
          if (got.no_tex !== want.no_tex) begin
            errors++;
            $display("%0t no_texture: expected %b actual %b", $time, want.no_tex,
                     got.no_tex);
          end
        end
      end
    end
  end

  // ---------------- test sequence ----------------
  // per phase: width, height, channel count, filter (extremes and the
  // out-of-range sizes and bad channel counts included)
  int phase_w [10] = '{256, 4, 1, 0, 511, 256, 5, 2, 17, 1};
  int phase_h [10] = '{256, 4, 1, 3, 7, 256, 300, 9, 13, 256};
  int phase_c [10] = '{4, 1, 2, 3, 4, 3, 0, 7, 2, 1};
  int phase_f [10] = '{0, 1, 0, 1, 1, 1, 1, 0, 1, 1};

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: sample with nothing loaded, then corner coordinates and bytes
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'hFFFF, 16'hFFFF);
    begin
      xact_t x;
      x.act = ACT_LOAD;
      x.data = {32'h0, 32'h0000_0000, 16'h0000};
      pending_q.push_back(x);
      queued_load[0] = 1'b1;
      x.data = {32'h0, 32'hFFFF_FFFF, 16'hFFFF};
      pending_q.push_back(x);
      queued_load[16'hFFFF] = 1'b1;
    end
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'hFFFF, 16'hFFFF);
    queue_sample(16'h8000, 16'h8000);
    queue_sample(16'h0000, 16'hFFFF);
    queue_sample(16'hFFFF, 16'h0000);
    queue_load(16'h1234);
    wait_idle();
    write_reg(REG_FILTER, 9'd1);
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'hFFFF, 16'hFFFF);
    queue_sample(16'h7FFF, 16'h0001);

    // each sample may add up to four tap loads, so phases stay short
    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      write_reg(REG_WIDTH, 9'(phase_w[ph]));
      write_reg(REG_HEIGHT, 9'(phase_h[ph]));
      write_reg(REG_CHAN, 9'(phase_c[ph]));
      write_reg(REG_FILTER, 9'(phase_f[ph]));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      for (int i = 0; i < 40; i++) begin
        if (i == 20 && ph == 3) begin
          // sender holds off until the pipe has drained
          while (pending_q.size() != 0 || s_tvalid || pixel_q.size() != 0) @(posedge clk);
        end
        if ($urandom_range(99) < 30) queue_load(16'($urandom));
        else queue_sample(16'($urandom), 16'($urandom));
      end
    end

    wait_idle();
    $display("Covered %0d texel loads and %0d samples over 11 register settings,",
             n_loads, n_samples);
    $display("%0d result transactions checked with random source gaps and sink stalls.",
             n_results);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
